FILE: design/lz4_block_decompressor_defines.svh
// Assertion macros used by the LZ4 block decompressor back end.
// No dependencies; files include this header by its bare name.
`ifndef LZ4_BLOCK_DECOMPRESSOR_DEFINES_SVH
`define LZ4_BLOCK_DECOMPRESSOR_DEFINES_SVH
`ifndef SYNTHESIS
`define LZ4D_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("lz4d assertion failed");
`define LZ4D_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lz4d assertion failed");
`else
`define LZ4D_ASSERT(lbl, clk, rstn, prop)
`define LZ4D_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: design/lz4d_pkg.sv
// Shared types and constants of the LZ4 block decompressor.
// No dependencies.
package lz4d_pkg;
    localparam int unsigned WINDOW_DEPTH = 65536;
    localparam int unsigned AW           = $clog2(WINDOW_DEPTH);
    localparam int unsigned LEN_W        = 29;
    localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};
    localparam int unsigned MAX_OUTPUT   = 268435456;
    localparam int unsigned QDEPTH       = 4;
    localparam int unsigned QPW          = $clog2(QDEPTH);
    localparam int unsigned PADDR_W      = 3;
    localparam logic [PADDR_W-1:0] REG_EXPECTED_SIZE = 3'd0;

    typedef enum logic [2:0] {
        PH_TOKEN, PH_LIT_EXT, PH_LITERAL, PH_OFF_LO,
        PH_OFF_HI, PH_MLEN_EXT, PH_COPY, PH_SWALLOW
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA, KIND_DONE, KIND_ERROR, KIND_BUSY
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE, ERR_TRUNCATED, ERR_BAD_OFFSET, ERR_OVERRUN, ERR_SHORT
    } t_err;

    // One queued command: an optional data byte then an optional report.
    typedef struct packed {
        logic          has_data;
        logic          copy;
        logic [7:0]    lit;
        logic [AW-1:0] rd_addr;
        logic [AW-1:0] wr_addr;
        logic          has_rep;
        t_kind         kind;
        t_err          code;
    } t_entry;
endpackage

FILE: design/lz4d_if.sv
// Stream channel interfaces of the LZ4 block decompressor.
// No dependencies.
interface lz4d_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] in_byte;
    logic       frame_end;
    modport source (output valid, mode, in_byte, frame_end, input ready);
    modport sink (input valid, mode, in_byte, frame_end, output ready);
endinterface

interface lz4d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    modport source (output valid, out_byte, kind, error_code, input ready);
    modport sink (input valid, out_byte, kind, error_code, output ready);
endinterface

FILE: design/lz4d_front.sv
// Front end: parses LZ4 sequences and issues byte and report commands.
// Depends on lz4d_pkg.
module lz4d_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_mode,
    input  logic [7:0]                  i_byte,
    input  logic                        i_frame_end,
    input  logic                        i_full,
    input  logic [lz4d_pkg::LEN_W-1:0]  i_expected,
    output logic                        o_ready,
    output logic                        o_push,
    output lz4d_pkg::t_entry            o_entry
);
    lz4d_pkg::t_phase          r_phase, n_phase;
    logic [lz4d_pkg::LEN_W-1:0] r_lit, n_lit, r_ml, n_ml, r_prod, n_prod;
    logic [3:0]                r_nib, n_nib;
    logic [15:0]               r_off, n_off;
    logic                      r_ended, n_ended;

    assign o_ready = !i_full;

    always_comb begin
        logic                      acc, fe, f_fail, f_lchk, f_mchk, f_ldone, f_eoi;
        logic                      f_after, f_new;
        lz4d_pkg::t_err            f_code;
        logic [lz4d_pkg::LEN_W:0]  sum;
        logic [15:0]               off;
        lz4d_pkg::t_entry          e;
        acc     = i_valid && !i_full;
        fe      = i_frame_end;
        f_fail  = 1'b0;
        f_lchk  = 1'b0;
        f_mchk  = 1'b0;
        f_ldone = 1'b0;
        f_eoi   = 1'b0;
        f_after = 1'b0;
        f_new   = 1'b0;
        f_code  = lz4d_pkg::ERR_NONE;
        sum     = '0;
        off     = '0;
        e       = '0;
        e.kind  = lz4d_pkg::KIND_DATA;
        e.code  = lz4d_pkg::ERR_NONE;
        n_phase = r_phase;
        n_lit   = r_lit;
        n_ml    = r_ml;
        n_prod  = r_prod;
        n_nib   = r_nib;
        n_off   = r_off;
        n_ended = r_ended;
        if (acc) begin
            if (i_mode) begin
                if (r_phase == lz4d_pkg::PH_COPY) begin
                    e.has_data = 1'b1;
                    e.copy     = 1'b1;
                    e.wr_addr  = r_prod[lz4d_pkg::AW-1:0];
                    e.rd_addr  = r_prod[lz4d_pkg::AW-1:0] - r_off[lz4d_pkg::AW-1:0];
                    n_prod     = r_prod + 1'b1;
                    n_ml       = r_ml - 1'b1;
                    if (n_ml == '0) begin
                        if (r_ended) begin
                            f_eoi = 1'b1;
                        end else if (n_prod >= i_expected) begin
                            e.has_rep = 1'b1;
                            e.kind    = lz4d_pkg::KIND_DONE;
                            n_phase   = lz4d_pkg::PH_SWALLOW;
                        end else begin
                            n_phase = lz4d_pkg::PH_TOKEN;
                        end
                    end
                end
            end else begin
                unique case (r_phase)
                    lz4d_pkg::PH_TOKEN: begin
                        if (r_prod >= i_expected) begin
                            e.has_rep = 1'b1;
                            e.kind    = lz4d_pkg::KIND_DONE;
                            f_after   = 1'b1;
                        end else if (32'(i_expected) > lz4d_pkg::MAX_OUTPUT) begin
                            f_fail = 1'b1;
                            f_code = lz4d_pkg::ERR_OVERRUN;
                        end else begin
                            n_lit = lz4d_pkg::LEN_W'(i_byte[7:4]);
                            n_nib = i_byte[3:0];
                            if (i_byte[7:4] == 4'hF) begin
                                if (fe) begin
                                    f_fail = 1'b1;
                                    f_code = lz4d_pkg::ERR_TRUNCATED;
                                end else begin
                                    n_phase = lz4d_pkg::PH_LIT_EXT;
                                end
                            end else begin
                                f_lchk = 1'b1;
                            end
                        end
                    end
                    lz4d_pkg::PH_LIT_EXT: begin
                        sum   = {1'b0, r_lit} + (lz4d_pkg::LEN_W + 1)'(i_byte);
                        n_lit = sum[lz4d_pkg::LEN_W] ? lz4d_pkg::LEN_SAT
                                                     : sum[lz4d_pkg::LEN_W-1:0];
                        if (i_byte == 8'hFF) begin
                            if (fe) begin
                                f_fail = 1'b1;
                                f_code = lz4d_pkg::ERR_TRUNCATED;
                            end
                        end else begin
                            f_lchk = 1'b1;
                        end
                    end
                    lz4d_pkg::PH_LITERAL: begin
                        e.has_data = 1'b1;
                        e.lit      = i_byte;
                        e.wr_addr  = r_prod[lz4d_pkg::AW-1:0];
                        n_prod     = r_prod + 1'b1;
                        n_lit      = r_lit - 1'b1;
                        if (n_lit == '0) begin
                            f_ldone = 1'b1;
                        end else if (fe) begin
                            f_fail = 1'b1;
                            f_code = lz4d_pkg::ERR_TRUNCATED;
                        end
                    end
                    lz4d_pkg::PH_OFF_LO: begin
                        n_off = {8'h00, i_byte};
                        if (fe) begin
                            f_fail = 1'b1;
                            f_code = lz4d_pkg::ERR_TRUNCATED;
                        end else begin
                            n_phase = lz4d_pkg::PH_OFF_HI;
                        end
                    end
                    lz4d_pkg::PH_OFF_HI: begin
                        off   = {i_byte, r_off[7:0]};
                        n_off = off;
                        if (off == '0 || lz4d_pkg::LEN_W'(off) > r_prod
                                || 32'(off) > lz4d_pkg::WINDOW_DEPTH) begin
                            f_fail = 1'b1;
                            f_code = lz4d_pkg::ERR_BAD_OFFSET;
                        end else begin
                            n_ml = lz4d_pkg::LEN_W'(r_nib) + lz4d_pkg::LEN_W'(4);
                            if (r_nib == 4'hF) begin
                                if (fe) begin
                                    f_fail = 1'b1;
                                    f_code = lz4d_pkg::ERR_TRUNCATED;
                                end else begin
                                    n_phase = lz4d_pkg::PH_MLEN_EXT;
                                end
                            end else begin
                                f_mchk = 1'b1;
                            end
                        end
                    end
                    lz4d_pkg::PH_MLEN_EXT: begin
                        sum  = {1'b0, r_ml} + (lz4d_pkg::LEN_W + 1)'(i_byte);
                        n_ml = sum[lz4d_pkg::LEN_W] ? lz4d_pkg::LEN_SAT
                                                    : sum[lz4d_pkg::LEN_W-1:0];
                        if (i_byte == 8'hFF) begin
                            if (fe) begin
                                f_fail = 1'b1;
                                f_code = lz4d_pkg::ERR_TRUNCATED;
                            end
                        end else begin
                            f_mchk = 1'b1;
                        end
                    end
                    lz4d_pkg::PH_COPY: begin
                        e.has_rep = 1'b1;
                        e.kind    = lz4d_pkg::KIND_BUSY;
                    end
                    lz4d_pkg::PH_SWALLOW: begin
                        f_new = fe;
                    end
                    default: begin
                        f_new = fe;
                    end
                endcase
            end
            // Each length check serves both the base and the extension bytes.
            if (f_lchk) begin
                if ({1'b0, r_prod} + {1'b0, n_lit} > {1'b0, i_expected}) begin
                    f_fail = 1'b1;
                    f_code = lz4d_pkg::ERR_OVERRUN;
                end else if (n_lit != '0) begin
                    if (fe) begin
                        f_fail = 1'b1;
                        f_code = lz4d_pkg::ERR_TRUNCATED;
                    end else begin
                        n_phase = lz4d_pkg::PH_LITERAL;
                    end
                end else begin
                    f_ldone = 1'b1;
                end
            end
            if (f_ldone) begin
                if (fe) begin
                    f_eoi = 1'b1;
                end else begin
                    n_phase = lz4d_pkg::PH_OFF_LO;
                end
            end
            if (f_mchk) begin
                if ({1'b0, r_prod} + {1'b0, n_ml} > {1'b0, i_expected}) begin
                    f_fail = 1'b1;
                    f_code = lz4d_pkg::ERR_OVERRUN;
                end else begin
                    n_ended = fe;
                    n_phase = lz4d_pkg::PH_COPY;
                end
            end
            if (f_fail) begin
                e.has_rep = 1'b1;
                e.kind    = lz4d_pkg::KIND_ERROR;
                e.code    = f_code;
                f_after   = 1'b1;
            end
            if (f_after) begin
                if (fe) begin
                    f_new = 1'b1;
                end else begin
                    n_phase = lz4d_pkg::PH_SWALLOW;
                end
            end
            if (f_eoi) begin
                e.has_rep = 1'b1;
                if (n_prod == i_expected) begin
                    e.kind = lz4d_pkg::KIND_DONE;
                end else begin
                    e.kind = lz4d_pkg::KIND_ERROR;
                    e.code = lz4d_pkg::ERR_SHORT;
                end
                f_new = 1'b1;
            end
            if (f_new) begin
                n_phase = lz4d_pkg::PH_TOKEN;
                n_lit   = '0;
                n_ml    = '0;
                n_nib   = '0;
                n_off   = '0;
                n_prod  = '0;
                n_ended = 1'b0;
            end
        end
        o_entry = e;
        o_push  = acc && (e.has_data || e.has_rep);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lz4d_pkg::PH_TOKEN;
            r_lit   <= '0;
            r_ml    <= '0;
            r_prod  <= '0;
            r_nib   <= '0;
            r_off   <= '0;
            r_ended <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_lit   <= n_lit;
            r_ml    <= n_ml;
            r_prod  <= n_prod;
            r_nib   <= n_nib;
            r_off   <= n_off;
            r_ended <= n_ended;
        end
    end
endmodule

FILE: design/lz4d_queue.sv
// Short command queue between the parser and the history back end.
// Depends on lz4d_pkg.
module lz4d_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lz4d_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output lz4d_pkg::t_entry o_head
);
    lz4d_pkg::t_entry           r_mem [lz4d_pkg::QDEPTH];
    logic [lz4d_pkg::QPW-1:0]   r_wp, r_rp;
    logic [lz4d_pkg::QPW:0]     r_cnt;

    assign o_full  = (r_cnt == (lz4d_pkg::QPW + 1)'(lz4d_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (lz4d_pkg::QPW + 1)'(i_push) - (lz4d_pkg::QPW + 1)'(i_pop);
        end
    end
endmodule

FILE: design/lz4d_back.sv
// Back end: history memory read and write, forwarding and output register.
// Depends on lz4d_pkg and lz4_block_decompressor_defines.svh.
`include "lz4_block_decompressor_defines.svh"
module lz4d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lz4d_pkg::t_entry i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic [1:0]       o_kind,
    output logic [2:0]       o_code
);
    logic [7:0]       r_hist [lz4d_pkg::WINDOW_DEPTH];
    logic             r_b1_v;
    lz4d_pkg::t_entry r_b1;
    logic [7:0]       r_rdata;
    logic             r_fwd;
    logic [7:0]       r_fwd_data;
    logic             r_b2_v;
    logic             r_b2_data_pend;
    logic [7:0]       r_b2_byte;
    logic             r_b2_rep;
    lz4d_pkg::t_kind  r_b2_kind;
    lz4d_pkg::t_err   r_b2_code;

    logic       w_show_data, w_acc, w_last, w_b2_free, w_move, w_load;
    logic [7:0] w_byte;

    assign w_show_data = r_b2_data_pend;
    assign o_valid     = r_b2_v;
    assign o_byte      = w_show_data ? r_b2_byte : 8'h00;
    assign o_kind      = w_show_data ? lz4d_pkg::KIND_DATA : r_b2_kind;
    assign o_code      = w_show_data ? lz4d_pkg::ERR_NONE : r_b2_code;
    assign w_acc       = r_b2_v && i_ready;
    assign w_last      = !w_show_data || !r_b2_rep;
    assign w_b2_free   = !r_b2_v || (w_acc && w_last);
    assign w_move      = r_b1_v && w_b2_free;
    assign w_load      = !i_empty && (!r_b1_v || w_move);
    assign o_pop       = w_load;
    assign w_byte      = !r_b1.copy ? r_b1.lit : (r_fwd ? r_fwd_data : r_rdata);

    always_ff @(posedge i_clk) begin
        if (w_move && r_b1.has_data) begin
            r_hist[r_b1.wr_addr] <= w_byte;
        end
    end

    // A read that hits the byte being written in the same cycle takes it
    // from the forwarding register instead of the memory.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rdata    <= r_hist[i_head.rd_addr];
            r_b1       <= i_head;
            r_fwd      <= w_move && r_b1.has_data && (i_head.rd_addr == r_b1.wr_addr);
            r_fwd_data <= w_byte;
        end
        if (w_move) begin
            r_b2_byte <= w_byte;
            r_b2_kind <= r_b1.kind;
            r_b2_code <= r_b1.code;
            r_b2_rep  <= r_b1.has_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v         <= 1'b0;
            r_b2_v         <= 1'b0;
            r_b2_data_pend <= 1'b0;
        end else begin
            if (w_load) begin
                r_b1_v <= 1'b1;
            end else if (w_move) begin
                r_b1_v <= 1'b0;
            end
            if (w_move) begin
                r_b2_v         <= 1'b1;
                r_b2_data_pend <= r_b1.has_data;
            end else if (w_acc) begin
                if (w_last) begin
                    r_b2_v         <= 1'b0;
                    r_b2_data_pend <= 1'b0;
                end else begin
                    r_b2_data_pend <= 1'b0;
                end
            end
        end
    end

    `LZ4D_ASSERT_NEXT(a_move_fills_out, i_clk, i_rst_n, w_move, r_b2_v)
    `LZ4D_ASSERT(a_pop_not_empty, i_clk, i_rst_n, !o_pop || !i_empty)
    `LZ4D_ASSERT(a_out_has_item, i_clk, i_rst_n, !r_b2_v || r_b2_data_pend || r_b2_rep)
    `LZ4D_ASSERT_NEXT(a_pop_loads_b1, i_clk, i_rst_n, o_pop, r_b1_v)
endmodule

FILE: design/lz4_block_decompressor.sv
// Streaming LZ4 block decompressor: one compressed byte or tick per transfer, one result
// per cycle out while the output is ready; a frame-parser front end feeds a 4-entry
// command queue, and a back end with a 64 KiB history memory (one read and one write
// port, registered read with same-cycle forwarding) produces the data bytes. A byte and a
// report from one transfer leave as two output items. The history needs no clearing pass
// after reset. Depends on lz4d_pkg, lz4d_if, lz4d_front, lz4d_queue and lz4d_back.
module lz4_block_decompressor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lz4d_in_if.sink                        i_in,
    lz4d_out_if.source                     o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lz4d_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    logic [lz4d_pkg::LEN_W-1:0] r_expected;
    logic                       w_full, w_push, w_empty, w_pop;
    lz4d_pkg::t_entry           w_entry, w_head;

    assign pready = 1'b1;
    assign prdata = (paddr == lz4d_pkg::REG_EXPECTED_SIZE) ? 32'(r_expected) : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0;
        end else if (psel && penable && pwrite && paddr == lz4d_pkg::REG_EXPECTED_SIZE) begin
            r_expected <= pwdata[lz4d_pkg::LEN_W-1:0];
        end
    end

    lz4d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_mode      (i_in.mode),
        .i_byte      (i_in.in_byte),
        .i_frame_end (i_in.frame_end),
        .i_full      (w_full),
        .i_expected  (r_expected),
        .o_ready     (i_in.ready),
        .o_push      (w_push),
        .o_entry     (w_entry)
    );

    lz4d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    lz4d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_byte  (o_out.out_byte),
        .o_kind  (o_out.kind),
        .o_code  (o_out.error_code)
    );
endmodule
